>>> sv/lbsm_pkg.sv
// Shared types, constants and step functions for the LCG bank sequence matcher.
package lbsm_pkg;

   localparam int NUM_GEN   = 14;
   localparam int NUM_LO8   = 6;
   localparam int NUM_MID24 = 5;

   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SEED   = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ENABLE = 2'd1;

   localparam logic [63:0]        RESET_SEED   = 64'd3;
   localparam logic [NUM_GEN-1:0] RESET_ENABLE = 14'h3FFF;

   // power-of-two generators drawing the low byte only need the low 8 state bits
   localparam logic [3:0] LO8_GEN [NUM_LO8] = '{4'd0, 4'd1, 4'd3, 4'd7, 4'd10, 4'd11};
   localparam logic [7:0] LO8_MUL [NUM_LO8] = '{8'h0D, 8'h35, 8'h6D, 8'hFD, 8'h2D, 8'hCD};
   localparam logic [7:0] LO8_ADD [NUM_LO8] = '{8'h5F, 8'h01, 8'h39, 8'hC3, 8'h4F, 8'h01};

   // power-of-two generators drawing bits 23..16 only need the low 24 state bits
   localparam logic [3:0]  MID24_GEN [NUM_MID24] = '{4'd2, 4'd4, 4'd5, 4'd6, 4'd12};
   localparam logic [23:0] MID24_MUL [NUM_MID24] =
      '{24'h5A4E35, 24'hC64E6D, 24'h088405, 24'h0343FD, 24'hECE66D};
   localparam logic [23:0] MID24_ADD [NUM_MID24] =
      '{24'h000001, 24'h003039, 24'h000001, 24'h269EC3, 24'h00000B};

   localparam logic [3:0] GEN_P31_LIN = 4'd8;
   localparam logic [3:0] GEN_P31_MUL = 4'd9;
   localparam logic [3:0] GEN_Q32     = 4'd13;

   localparam logic [30:0] MOD31       = 31'h7FFF_FFFF;
   localparam logic [31:0] MOD32M5     = 32'hFFFF_FFFB;
   localparam logic [35:0] P31_LIN_MUL = 36'd18;
   localparam logic [35:0] P31_LIN_ADD = 36'd60;
   localparam logic [45:0] P31_MUL     = 46'd16807;
   localparam logic [60:0] Q32_NEG_MUL = 61'd333333328;

   typedef logic [NUM_GEN-1:0]      gen_mask_type;
   typedef logic [NUM_GEN-1:0][7:0] draw_type;

   typedef struct packed {
      logic         load;
      logic [63:0]  seed;
      gen_mask_type step;
   } gen_ctrl_type;

   typedef struct packed {
      logic         load;
      gen_mask_type enable;
      logic         advance;
      logic [7:0]   obs;
   } core_ctrl_type;

   typedef struct packed {
      gen_mask_type active_set;
      gen_mask_type newly_failed;
      logic [3:0]   remaining;
      logic         ignored;
   } match_result_type;

   function automatic logic [3:0] count_gen(input gen_mask_type v);
      logic [3:0] n;
      n = '0;
      for (int i = 0; i < NUM_GEN; i++) begin
         n = n + 4'(v[i]);
      end
      return n;
   endfunction

   function automatic logic [7:0] lcg8(input logic [7:0] x, input logic [7:0] a,
                                       input logic [7:0] c);
      return x * a + c;
   endfunction

   function automatic logic [23:0] lcg24(input logic [23:0] x, input logic [23:0] a,
                                         input logic [23:0] c);
      return x * a + c;
   endfunction

   // (2147483629*x + 2147483587) mod p equals -(18*x + 60) mod p
   function automatic logic [30:0] step_p31_lin(input logic [30:0] x);
      logic [35:0] t;
      logic [31:0] f;
      logic [30:0] r;
      t = 36'(x) * P31_LIN_MUL + P31_LIN_ADD;
      f = {1'b0, t[30:0]} + 32'(t[35:31]);
      r = (f >= {1'b0, MOD31}) ? 31'(f - {1'b0, MOD31}) : f[30:0];
      return (r == '0) ? '0 : MOD31 - r;
   endfunction

   function automatic logic [30:0] step_p31_mul(input logic [30:0] x);
      logic [45:0] t;
      logic [31:0] f;
      t = 46'(x) * P31_MUL;
      f = {1'b0, t[30:0]} + 32'(t[45:31]);
      return (f >= {1'b0, MOD31}) ? 31'(f - {1'b0, MOD31}) : f[30:0];
   endfunction

   // multiplier is congruent to -333333328 mod 2^32-5, and 2^32 folds to 5
   function automatic logic [31:0] step_q32(input logic [31:0] x);
      logic [60:0] t;
      logic [33:0] f1;
      logic [32:0] f2;
      logic [31:0] r;
      t  = 61'(x) * Q32_NEG_MUL;
      f1 = 34'(t[31:0]) + 34'(t[60:32]) * 34'd5;
      f2 = 33'(f1[31:0]) + 33'(f1[33:32]) * 33'd5;
      r  = (f2 >= {1'b0, MOD32M5}) ? 32'(f2 - {1'b0, MOD32M5}) : f2[31:0];
      return (r == '0) ? '0 : MOD32M5 - r;
   endfunction

endpackage

>>> sv/lbsm_gen_bank.sv
// Generator state registers and their next-state logic, one drawn byte per generator.
module lbsm_gen_bank
   import lbsm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  gen_ctrl_type ctrl,
   output draw_type     draw
);

   logic [7:0]  lo8_ff    [NUM_LO8];
   logic [7:0]  lo8_in    [NUM_LO8];
   logic [7:0]  lo8_adv   [NUM_LO8];
   logic [23:0] mid24_ff  [NUM_MID24];
   logic [23:0] mid24_in  [NUM_MID24];
   logic [23:0] mid24_adv [NUM_MID24];
   logic [30:0] p31_lin_ff, p31_lin_in, p31_lin_adv;
   logic [30:0] p31_mul_ff, p31_mul_in, p31_mul_adv;
   logic [31:0] q32_ff, q32_in, q32_adv;

   always_comb begin
      draw = '0;
      for (int i = 0; i < NUM_LO8; i++) begin
         lo8_adv[i] = lcg8(lo8_ff[i], LO8_MUL[i], LO8_ADD[i]);
         draw[LO8_GEN[i]] = lo8_adv[i];
         lo8_in[i] = ctrl.load ? ctrl.seed[7:0] :
                     ctrl.step[LO8_GEN[i]] ? lo8_adv[i] : lo8_ff[i];
      end
      for (int i = 0; i < NUM_MID24; i++) begin
         mid24_adv[i] = lcg24(mid24_ff[i], MID24_MUL[i], MID24_ADD[i]);
         draw[MID24_GEN[i]] = mid24_adv[i][23:16];
         mid24_in[i] = ctrl.load ? ctrl.seed[23:0] :
                       ctrl.step[MID24_GEN[i]] ? mid24_adv[i] : mid24_ff[i];
      end
      p31_lin_adv = step_p31_lin(p31_lin_ff);
      p31_mul_adv = step_p31_mul(p31_mul_ff);
      q32_adv     = step_q32(q32_ff);
      draw[GEN_P31_LIN] = p31_lin_adv[7:0];
      draw[GEN_P31_MUL] = p31_mul_adv[7:0];
      draw[GEN_Q32]     = q32_adv[7:0];
      p31_lin_in = ctrl.load ? ctrl.seed[30:0] :
                   ctrl.step[GEN_P31_LIN] ? p31_lin_adv : p31_lin_ff;
      p31_mul_in = ctrl.load ? ctrl.seed[30:0] :
                   ctrl.step[GEN_P31_MUL] ? p31_mul_adv : p31_mul_ff;
      q32_in     = ctrl.load ? ctrl.seed[31:0] :
                   ctrl.step[GEN_Q32] ? q32_adv : q32_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_LO8; i++) lo8_ff[i] <= RESET_SEED[7:0];
         for (int i = 0; i < NUM_MID24; i++) mid24_ff[i] <= RESET_SEED[23:0];
         p31_lin_ff <= RESET_SEED[30:0];
         p31_mul_ff <= RESET_SEED[30:0];
         q32_ff     <= RESET_SEED[31:0];
      end else begin
         lo8_ff     <= lo8_in;
         mid24_ff   <= mid24_in;
         p31_lin_ff <= p31_lin_in;
         p31_mul_ff <= p31_mul_in;
         q32_ff     <= q32_in;
      end
   end

endmodule

>>> sv/lbsm_match_core.sv
// Active set and live count tracking, byte compare against every active generator.
module lbsm_match_core
   import lbsm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  core_ctrl_type    ctrl,
   input  draw_type         draw,
   output gen_mask_type     step,
   output match_result_type res
);

   gen_mask_type active_ff, active_in;
   logic [3:0]   live_ff, live_in;
   gen_mask_type failed;
   gen_mask_type next_active;
   logic [3:0]   next_live;
   logic         none_live;

   always_comb begin
      none_live = (live_ff == '0) || (active_ff == '0);
      for (int g = 0; g < NUM_GEN; g++) begin
         failed[g] = !none_live && active_ff[g] && (draw[g] != ctrl.obs);
      end
      next_active = active_ff & ~failed;
      next_live   = count_gen(next_active);

      step = (ctrl.advance && !none_live) ? active_ff : '0;

      res.active_set   = none_live ? '0 : next_active;
      res.newly_failed = failed;
      res.remaining    = none_live ? '0 : next_live;
      res.ignored      = none_live;

      active_in = active_ff;
      live_in   = live_ff;
      if (ctrl.load) begin
         active_in = ctrl.enable;
         live_in   = count_gen(ctrl.enable);
      end else if (ctrl.advance && !none_live) begin
         active_in = next_active;
         live_in   = next_live;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= RESET_ENABLE;
         live_ff   <= count_gen(RESET_ENABLE);
      end else begin
         active_ff <= active_in;
         live_ff   <= live_in;
      end
   end

endmodule

>>> sv/lcg_bank_sequence_matcher.sv
// Top level: input register, configuration registers, position counter, result register.
// An accepted item is held in the input register, then its result is registered in the result register.
// Throughput: one item per cycle while the result register is empty or rsp_ready is high; the bound is the
// combinational generator next-state step, deepest in the mod 2^32-5 multiply and fold.
// Reset restores seed 3 and all fourteen generators enabled, position zero; no clearing pass.
// A write to the seed or enable register restarts every generator from the seed in the same cycle.
module lcg_bank_sequence_matcher
   import lbsm_pkg::*;
#(
   parameter int POSITION_BITS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [7:0]                req_observed_byte,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [NUM_GEN-1:0]        rsp_active_set,
   output logic [NUM_GEN-1:0]        rsp_newly_failed,
   output logic [3:0]                rsp_remaining,
   output logic [31:0]               rsp_byte_position,
   output logic                      rsp_ignored,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [63:0]               csr_data
);

   localparam int POS_EXT_BITS = (POSITION_BITS > 32) ? POSITION_BITS : 32;

   logic [63:0]              seed_ff, seed_in;
   gen_mask_type             enable_ff, enable_in;
   logic                     in_valid_ff, in_valid_in;
   logic [7:0]               in_byte_ff, in_byte_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [POS_EXT_BITS-1:0]  pos_ext;
   logic [31:0]              pos_out;
   logic                     rsp_valid_ff, rsp_valid_in;
   match_result_type         rsp_res_ff, rsp_res_in;
   logic [31:0]              rsp_pos_ff, rsp_pos_in;

   logic             csr_write;
   logic             load;
   logic             advance;
   gen_ctrl_type     gen_ctrl;
   core_ctrl_type    core_ctrl;
   draw_type         draw;
   gen_mask_type     step;
   match_result_type res;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign load      = csr_write && (csr_index == CSR_SEED || csr_index == CSR_ENABLE);

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      seed_in   = seed_ff;
      enable_in = enable_ff;
      if (csr_write && csr_index == CSR_SEED) seed_in = csr_data;
      if (csr_write && csr_index == CSR_ENABLE) enable_in = csr_data[NUM_GEN-1:0];

      gen_ctrl.load  = load;
      gen_ctrl.seed  = seed_in;
      gen_ctrl.step  = step;

      core_ctrl.load    = load;
      core_ctrl.enable  = enable_in;
      core_ctrl.advance = advance;
      core_ctrl.obs     = in_byte_ff;
   end

   lbsm_gen_bank u_gen_bank (
      .clock (clock),
      .reset (reset),
      .ctrl  (gen_ctrl),
      .draw  (draw)
   );

   lbsm_match_core u_match_core (
      .clock (clock),
      .reset (reset),
      .ctrl  (core_ctrl),
      .draw  (draw),
      .step  (step),
      .res   (res)
   );

   always_comb begin
      pos_ext = POS_EXT_BITS'(pos_ff);
      pos_out = (pos_ext > POS_EXT_BITS'(32'hFFFF_FFFF)) ? '1 : pos_ext[31:0];

      pos_in = pos_ff;
      if (load) begin
         pos_in = '0;
      end else if (advance && !res.ignored && pos_ff != '1) begin
         pos_in = pos_ff + POSITION_BITS'(1);
      end

      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_observed_byte;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_res_in   = rsp_res_ff;
      rsp_pos_in   = rsp_pos_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_res_in   = res;
         rsp_pos_in   = pos_out;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff      <= RESET_SEED;
         enable_ff    <= RESET_ENABLE;
         in_valid_ff  <= 1'b0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seed_ff      <= seed_in;
         enable_ff    <= enable_in;
         in_valid_ff  <= in_valid_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      in_byte_ff <= in_byte_in;
      rsp_res_ff <= rsp_res_in;
      rsp_pos_ff <= rsp_pos_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_active_set    = rsp_res_ff.active_set;
   assign rsp_newly_failed  = rsp_res_ff.newly_failed;
   assign rsp_remaining     = rsp_res_ff.remaining;
   assign rsp_byte_position = rsp_pos_ff;
   assign rsp_ignored       = rsp_res_ff.ignored;

   a_fail_not_active: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_active_set & rsp_newly_failed) == '0)
      else $error("failed generator still reported active");

   a_remaining_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_remaining == 4'($countones(rsp_active_set)))
      else $error("remaining count disagrees with active set");

   a_ignored_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ignored |-> rsp_active_set == '0 && rsp_newly_failed == '0)
      else $error("ignored item carries generator bits");

   a_restart_position: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready && (csr_index == CSR_SEED || csr_index == CSR_ENABLE)
      |=> pos_ff == '0)
      else $error("position not cleared by restart");

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for lcg_bank_sequence_matcher with a predicting scoreboard.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import lbsm_pkg::*;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_HI = 2'd3;
   localparam int GEN_WIDE = 10;

   typedef struct packed {
      gen_mask_type active_set;
      gen_mask_type newly_failed;
      logic [3:0]   remaining;
      logic [31:0]  position;
      logic         ignored;
   } match_expect_type;

   class match_scoreboard;
      localparam logic [63:0] PRIME31 = 64'd2147483647;
      localparam logic [63:0] NEAR32  = 64'd4294967291;
      localparam gen_mask_type MID_DRAW = 14'b01_0000_0111_0100;

      logic [63:0]      seed_reg;
      gen_mask_type     enable_reg;
      logic [63:0]      gen_state [NUM_GEN];
      gen_mask_type     active;
      logic [3:0]       live;
      logic [31:0]      position;
      match_expect_type expected_q [$];
      int               errors;

      function logic [63:0] state_mask(int g);
         case (g)
            7: return 64'h0000_0000_00FF_FFFF;
            10: return '1;
            12: return 64'h0000_FFFF_FFFF_FFFF;
            3, 4, 8, 9: return 64'h0000_0000_7FFF_FFFF;
            default: return 64'h0000_0000_FFFF_FFFF;
         endcase
      endfunction

      function logic [63:0] next_state(int g, logic [63:0] x);
         logic [63:0] n;
         case (g)
            0: n = 64'd1664525 * x + 64'd1013904223;
            1, 2: n = 64'd22695477 * x + 64'd1;
            3, 4: n = 64'd1103515245 * x + 64'd12345;
            5: n = 64'd134775813 * x + 64'd1;
            6: n = 64'd214013 * x + 64'd2531011;
            7: n = 64'd1140671485 * x + 64'd12820163;
            8: n = (64'd2147483629 * x + 64'd2147483587) % PRIME31;
            9: n = (64'd16807 * x) % PRIME31;
            10: n = 64'd6364136223846793005 * x + 64'd1442695040888963407;
            11: n = 64'd69069 * x + 64'd1;
            12: n = 64'd25214903917 * x + 64'd11;
            default: n = (64'd3961633963 * x) % NEAR32;
         endcase
         return n & state_mask(g);
      endfunction

      function logic [7:0] draw_of(int g, logic [63:0] x);
         return MID_DRAW[g] ? x[23:16] : x[7:0];
      endfunction

      function void restart();
         for (int g = 0; g < NUM_GEN; g++) begin
            gen_state[g] = seed_reg & state_mask(g);
         end
         active   = enable_reg;
         live     = 4'($countones(enable_reg));
         position = '0;
      endfunction

      function void reset_state();
         seed_reg   = RESET_SEED;
         enable_reg = RESET_ENABLE;
         errors     = 0;
         expected_q.delete();
         restart();
      endfunction

      function void write_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [63:0] data);
         if (idx == CSR_SEED) begin
            seed_reg = data;
            restart();
         end else if (idx == CSR_ENABLE) begin
            enable_reg = data[NUM_GEN-1:0];
            restart();
         end
      endfunction

      function logic [7:0] peek_draw(int g);
         return draw_of(g, next_state(g, gen_state[g]));
      endfunction

      function void note_byte(logic [7:0] obs);
         match_expect_type e;
         gen_mask_type     failed;
         failed     = '0;
         e.position = position;
         if (live == 0 || active == '0) begin
            e.active_set   = '0;
            e.newly_failed = '0;
            e.remaining    = '0;
            e.ignored      = 1'b1;
         end else begin
            for (int g = 0; g < NUM_GEN; g++) begin
               if (active[g]) begin
                  gen_state[g] = next_state(g, gen_state[g]);
                  if (draw_of(g, gen_state[g]) != obs) failed[g] = 1'b1;
               end
            end
            active = active & ~failed;
            live   = 4'($countones(active));
            if (position != '1) position = position + 1;
            e.active_set   = active;
            e.newly_failed = failed;
            e.remaining    = live;
            e.ignored      = 1'b0;
         end
         expected_q.push_back(e);
      endfunction

      task report(string msg);
         errors++;
         $display("tb: mismatch: %s", msg);
      endtask

      task check_result(match_expect_type got);
         match_expect_type e;
         if (expected_q.size() == 0) begin
            report("result item with no item outstanding");
            return;
         end
         e = expected_q.pop_front();
         if (got.active_set !== e.active_set)
            report($sformatf("pos %0d active_set %h, want %h",
                             e.position, got.active_set, e.active_set));
         if (got.newly_failed !== e.newly_failed)
            report($sformatf("pos %0d newly_failed %h, want %h",
                             e.position, got.newly_failed, e.newly_failed));
         if (got.remaining !== e.remaining)
            report($sformatf("pos %0d remaining %0d, want %0d",
                             e.position, got.remaining, e.remaining));
         if (got.position !== e.position)
            report($sformatf("byte_position %0d, want %0d", got.position, e.position));
         if (got.ignored !== e.ignored)
            report($sformatf("pos %0d ignored %b, want %b",
                             e.position, got.ignored, e.ignored));
      endtask

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic [7:0]                req_observed_byte;
   logic                      rsp_valid;
   logic                      rsp_ready;
   gen_mask_type              rsp_active_set;
   gen_mask_type              rsp_newly_failed;
   logic [3:0]                rsp_remaining;
   logic [31:0]               rsp_byte_position;
   logic                      rsp_ignored;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [63:0]               csr_data;

   match_scoreboard sb;
   int sent_items;
   int accepted_items;

   lcg_bank_sequence_matcher uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_observed_byte (req_observed_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_active_set    (rsp_active_set),
      .rsp_newly_failed  (rsp_newly_failed),
      .rsp_remaining     (rsp_remaining),
      .rsp_byte_position (rsp_byte_position),
      .rsp_ignored       (rsp_ignored),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("tb: failure");
      $finish;
   end

   always @(posedge clock) begin : monitor
      match_expect_type got;
      if (!reset) begin
         if (csr_valid && csr_ready) sb.write_reg(csr_index, csr_data);
         if (req_valid && req_ready) begin
            sb.note_byte(req_observed_byte);
            accepted_items++;
         end
         if (rsp_valid && rsp_ready) begin
            got.active_set   = rsp_active_set;
            got.newly_failed = rsp_newly_failed;
            got.remaining    = rsp_remaining;
            got.position     = rsp_byte_position;
            got.ignored      = rsp_ignored;
            sb.check_result(got);
         end
      end
   end

   initial begin : receiver
      int hold;
      bit held;
      hold = 0;
      held = 1'b0;
      @(negedge reset);
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            hold--;
         end else if (!held && accepted_items >= 300) begin
            held = 1'b1;
            hold = 150;
            rsp_ready <= 1'b0;
         end else if (sent_items >= 900 && sent_items < 1200) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= 10);
         end
      end
   end

   task automatic send_byte(input logic [7:0] b);
      while (!(sent_items >= 900 && sent_items < 1200) && $urandom_range(0, 99) < 10) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_observed_byte <= b;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] idx, input logic [63:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
   endtask

   function automatic int choose_gen(input gen_mask_type mask);
      int g;
      if (mask == '0) return 0;
      do g = $urandom_range(0, NUM_GEN - 1); while (!mask[g]);
      return g;
   endfunction

   function automatic logic [7:0] pick_byte(input int target);
      int r;
      r = $urandom_range(0, 99);
      if (r < 5) return 8'($urandom);
      if (r < 92 && sb.active[target]) return sb.peek_draw(target);
      return sb.peek_draw(choose_gen(sb.active));
   endfunction

   function automatic logic [63:0] rand_seed();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return 64'hFFFF_FFFF_FFFF_FFFB + 64'($urandom_range(0, 4));
         3: return {$urandom, 32'h7FFF_FFFC + 32'($urandom_range(0, 7))};
         4: return {32'd0, $urandom};
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic gen_mask_type rand_mask();
      case ($urandom_range(0, 9))
         0: return '1;
         1, 2: return gen_mask_type'(1) << $urandom_range(0, NUM_GEN - 1);
         3: return '0;
         default: return gen_mask_type'($urandom);
      endcase
   endfunction

   task automatic run_phase(input logic [63:0] seed, input gen_mask_type mask, input int n,
                            input bit set_seed, input bit set_mask);
      int target;
      int counted;
      int idle_sent;
      drain();
      if (set_seed) write_csr(CSR_SEED, seed);
      if (set_mask) write_csr(CSR_ENABLE, 64'(mask));
      csr_valid <= 1'b0;
      target    = choose_gen(sb.active);
      counted   = 0;
      idle_sent = 0;
      while (counted < n && idle_sent < 3) begin
         if (sb.active == '0) begin
            idle_sent++;
            send_byte(8'($urandom));
         end else begin
            counted++;
            sent_items++;
            send_byte(pick_byte(target));
         end
      end
   endtask

   initial begin : stimulus
      int sel;
      int wait_cycles;
      sb = new();
      sb.reset_state();
      sent_items        = 0;
      accepted_items    = 0;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_observed_byte = '0;
      rsp_ready         = 1'b0;
      csr_valid         = 1'b0;
      csr_index         = '0;
      csr_data          = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: follow one generator, then the byte extremes
      repeat (4) begin
         sent_items++;
         send_byte(sb.peek_draw(GEN_WIDE));
      end
      sent_items += 2;
      send_byte(8'h00);
      send_byte(8'hFF);

      // modular states loaded at or above their modulus
      run_phase('1, gen_mask_type'(1) << GEN_P31_LIN, 3, 1'b1, 1'b1);
      run_phase('1, gen_mask_type'(1) << GEN_P31_MUL, 3, 1'b0, 1'b1);
      run_phase('1, gen_mask_type'(1) << GEN_Q32, 3, 1'b0, 1'b1);

      // writes to unmapped indexes must not restart the search
      drain();
      write_csr(CSR_SPARE_LO, {$urandom, $urandom});
      write_csr(CSR_SPARE_HI, {$urandom, $urandom});
      csr_valid <= 1'b0;
      repeat (2) begin
         sent_items++;
         send_byte(sb.peek_draw(GEN_Q32));
      end

      run_phase({$urandom, $urandom}, '0, 1, 1'b1, 1'b1);

      while (sent_items < 1720) begin
         sel = $urandom_range(0, 2);
         run_phase(rand_seed(), rand_mask(), $urandom_range(5, 80), sel != 2, sel != 1);
      end

      req_valid <= 1'b0;
      wait_cycles = 0;
      while (sb.pending() != 0 && wait_cycles < 2000) begin
         @(negedge clock);
         wait_cycles++;
      end
      repeat (10) @(negedge clock);
      if (sb.pending() != 0)
         sb.report($sformatf("%0d result items never arrived", sb.pending()));
      if (sb.errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
